// ===== src/crtc_rfd_pkg.sv =====
`timescale 1ns / 1ps

package crtc_rfd_pkg;

    // register file geometry
    localparam int REG_COUNT = 18;
    localparam int REG_SEL_W = 5;
    localparam int REG_IDX_W = $clog2(REG_COUNT);

    // access kinds and port selects
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;
    localparam logic PORT_INDEX = 1'b0;
    localparam logic PORT_DATA  = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_CURSOR_ENABLE = 2'd0;
    localparam logic [1:0] CFG_DOUBLE_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_VRAM_MASK     = 2'd2;

    // controller register numbers with decoded side effects
    localparam logic [REG_SEL_W-1:0] REG_H_DISPLAYED  = 5'd1;
    localparam logic [REG_SEL_W-1:0] REG_V_DISPLAYED  = 5'd6;
    localparam logic [REG_SEL_W-1:0] REG_MAX_SCAN     = 5'd9;
    localparam logic [REG_SEL_W-1:0] REG_CURSOR_START = 5'd10;
    localparam logic [REG_SEL_W-1:0] REG_CURSOR_END   = 5'd11;
    localparam logic [REG_SEL_W-1:0] REG_START_HI     = 5'd12;
    localparam logic [REG_SEL_W-1:0] REG_START_LO     = 5'd13;
    localparam logic [REG_SEL_W-1:0] REG_CURSOR_HI    = 5'd14;
    localparam logic [REG_SEL_W-1:0] REG_CURSOR_LO    = 5'd15;

    // cursor mode field codes (bits 6:5 of cursor start register)
    localparam logic [1:0] CUR_MODE_STEADY = 2'b00;
    localparam logic [1:0] CUR_MODE_OFF    = 2'b01;
    localparam logic [1:0] CUR_MODE_SLOW   = 2'b11;

    localparam logic [5:0] BLINK_FAST = 6'd16;
    localparam logic [5:0] BLINK_SLOW = 6'd32;

    // reset values of decoded settings
    localparam logic [8:0] RST_COLUMNS = 9'd80;
    localparam logic [7:0] RST_ROWS    = 8'd25;
    localparam logic [5:0] RST_HEIGHT  = 6'd8;
    localparam logic [4:0] RST_LAST    = 5'd7;

    localparam logic [7:0] READ_NONE = 8'hff;

    typedef logic [7:0] t_byte;

endpackage

// ===== src/crtc_register_file_decode_core.sv =====
`timescale 1ns / 1ps

// crt controller register interface with decoded display settings
//
// input channel: one bus access per beat (i_func write/read, i_port index/data,
// i_data byte), handshake i_valid / o_stall. output channel: one result beat per
// input beat, handshake o_valid / i_stall, carrying the read byte and the
// decoded settings as they stand after that access.
// the result is registered and appears in the cycle after the input beat.
// throughput: one access per cycle while o_stall is low; the index register, the 18-entry register
// file and the decoded settings all update in the accepting cycle, the single
// output register is the only stage.
// stall: while a result waits and i_stall is high, o_stall is raised and the
// result with its settings holds; when the waiting result is taken in the same
// cycle a new beat may enter.
// reset (synchronous, active low): index and register file zero, 80 columns,
// 25 rows, height 8, cursor hidden, blinking, period 16, lines 0..7, addresses
// and size zero; configuration back to cursor enabled, single width, full mask.
// configuration writes take effect the next time the dependent register is
// written; already decoded settings are not recomputed.
module crtc_register_file_decode_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic        i_port,
    input  logic [7:0]  i_data,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_read_data,
    output logic [8:0]  o_text_columns,
    output logic [7:0]  o_text_rows,
    output logic [5:0]  o_char_height,
    output logic        o_cursor_visible,
    output logic        o_cursor_blink,
    output logic [5:0]  o_blink_period,
    output logic [4:0]  o_cursor_first_line,
    output logic [4:0]  o_cursor_last_line,
    output logic [15:0] o_start_address,
    output logic [11:0] o_cursor_address,
    output logic [16:0] o_video_size
);
    import crtc_rfd_pkg::*;

    // configuration
    logic        r_cursor_enable;
    logic        r_double_width;
    logic [15:0] r_vram_mask;

    // controller state
    t_byte       r_reg_index;
    t_byte       r_reg_file [REG_COUNT];
    t_byte       n_reg_file [REG_COUNT];
    t_byte       n_reg_index;

    // decoded settings, these drive the result fields directly
    logic [8:0]  r_columns, n_columns;
    logic [7:0]  r_rows, n_rows;
    logic [5:0]  r_height, n_height;
    logic        r_visible, n_visible;
    logic        r_blink, n_blink;
    logic [5:0]  r_period, n_period;
    logic [4:0]  r_first, n_first;
    logic [4:0]  r_last, n_last;
    logic [15:0] r_start, n_start;
    logic [11:0] r_cursor, n_cursor;
    logic [16:0] r_size, n_size;

    // result register
    logic        r_out_valid;
    t_byte       r_read_data, n_read_data;

    logic                 w_accept;
    logic [REG_SEL_W-1:0] w_sel;
    logic                 w_in_range;
    logic [REG_IDX_W-1:0] w_idx;
    logic [1:0]           w_mode;
    logic                 w_data_write;

    // a waiting result blocks input only while it is itself stalled
    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    assign w_sel        = r_reg_index[REG_SEL_W-1:0];
    assign w_in_range   = ({1'b0, w_sel} < (REG_SEL_W + 1)'(REG_COUNT));
    assign w_idx        = w_sel[REG_IDX_W-1:0];
    assign w_mode       = i_data[6:5];
    assign w_data_write = (i_func == FUNC_WRITE) && (i_port == PORT_DATA) && w_in_range;

    always_comb begin
        n_reg_index = r_reg_index;
        n_reg_file  = r_reg_file;
        n_columns   = r_columns;
        n_rows      = r_rows;
        n_height    = r_height;
        n_visible   = r_visible;
        n_blink     = r_blink;
        n_period    = r_period;
        n_first     = r_first;
        n_last      = r_last;
        n_start     = r_start;
        n_cursor    = r_cursor;
        n_read_data = READ_NONE;

        if (i_func == FUNC_WRITE) begin
            if (i_port == PORT_INDEX) begin
                n_reg_index = i_data;
            end else if (w_in_range) begin
                n_reg_file[w_idx] = i_data;
            end
        end else begin
            if (i_port == PORT_INDEX) begin
                n_read_data = r_reg_index;
            end else if (w_in_range) begin
                n_read_data = r_reg_file[w_idx];
            end
        end

        if (w_data_write) begin
            case (w_sel)
                REG_H_DISPLAYED: begin
                    n_columns = r_double_width ? {i_data, 1'b0} : {1'b0, i_data};
                end
                REG_V_DISPLAYED: begin
                    n_rows = i_data;
                end
                REG_MAX_SCAN: begin
                    n_height = {1'b0, i_data[4:0]} + 6'd1;
                end
                REG_CURSOR_START: begin
                    n_visible = (w_mode != CUR_MODE_OFF) && r_cursor_enable;
                    n_blink   = (w_mode != CUR_MODE_STEADY);
                    n_period  = (w_mode == CUR_MODE_SLOW) ? BLINK_SLOW : BLINK_FAST;
                    n_first   = i_data[4:0];
                end
                REG_CURSOR_END: begin
                    n_last = i_data[4:0];
                end
                REG_START_HI, REG_START_LO: begin
                    n_start = {n_reg_file[REG_IDX_W'(REG_START_HI)],
                               n_reg_file[REG_IDX_W'(REG_START_LO)]} & r_vram_mask;
                end
                REG_CURSOR_HI, REG_CURSOR_LO: begin
                    n_cursor = {n_reg_file[REG_IDX_W'(REG_CURSOR_HI)][3:0],
                                n_reg_file[REG_IDX_W'(REG_CURSOR_LO)]};
                end
                default: begin
                end
            endcase
        end

        // 9 x 8 product, exact in 17 bits
        n_size = r_size;
        if (w_data_write && ((w_sel == REG_H_DISPLAYED) || (w_sel == REG_V_DISPLAYED))) begin
            n_size = 17'(n_columns) * 17'(n_rows);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_enable <= 1'b1;
            r_double_width  <= 1'b0;
            r_vram_mask     <= 16'hffff;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CURSOR_ENABLE: r_cursor_enable <= i_cfg_data[0];
                CFG_DOUBLE_WIDTH:  r_double_width  <= i_cfg_data[0];
                CFG_VRAM_MASK:     r_vram_mask     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_index <= '0;
            for (int k = 0; k < REG_COUNT; k++) begin
                r_reg_file[k] <= '0;
            end
            r_columns   <= RST_COLUMNS;
            r_rows      <= RST_ROWS;
            r_height    <= RST_HEIGHT;
            r_visible   <= 1'b0;
            r_blink     <= 1'b1;
            r_period    <= BLINK_FAST;
            r_first     <= '0;
            r_last      <= RST_LAST;
            r_start     <= '0;
            r_cursor    <= '0;
            r_size      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_reg_index <= n_reg_index;
                r_reg_file  <= n_reg_file;
                r_columns   <= n_columns;
                r_rows      <= n_rows;
                r_height    <= n_height;
                r_visible   <= n_visible;
                r_blink     <= n_blink;
                r_period    <= n_period;
                r_first     <= n_first;
                r_last      <= n_last;
                r_start     <= n_start;
                r_cursor    <= n_cursor;
                r_size      <= n_size;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // read byte is payload only
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_data <= n_read_data;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_read_data         = r_read_data;
    assign o_text_columns      = r_columns;
    assign o_text_rows         = r_rows;
    assign o_char_height       = r_height;
    assign o_cursor_visible    = r_visible;
    assign o_cursor_blink      = r_blink;
    assign o_blink_period      = r_period;
    assign o_cursor_first_line = r_first;
    assign o_cursor_last_line  = r_last;
    assign o_start_address     = r_start;
    assign o_cursor_address    = r_cursor;
    assign o_video_size        = r_size;

endmodule
